FILE: rtl/half_float_multiply_unit_assert.svh
// Assertion macros for the port-level checker file.
`ifndef HALF_FLOAT_MULTIPLY_UNIT_ASSERT_SVH
`define HALF_FLOAT_MULTIPLY_UNIT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define HFM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define HFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/hfm_pkg.sv
// ----------------------------------------------------------------------------
// hfm_pkg
// Constants and the binary16 product function for the half float multiplier.
// ----------------------------------------------------------------------------
package hfm_pkg;

  localparam logic [15:0] SIGN_MASK = 16'h8000;
  localparam logic [15:0] INF_BITS  = 16'h7c00;
  localparam logic [4:0]  EXP_MAX   = 5'h1f;

  // Leading zero count of a 10-bit fraction (fraction nonzero)
  function automatic logic [3:0] lzc10(input logic [9:0] m);
    logic [3:0] n;
    n = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (m[i]) n = 4'(9 - i);
    end
    return n;
  endfunction

  // Full binary16 multiply, round to nearest even
  function automatic logic [15:0] hmul(input logic [15:0] a, input logic [15:0] b);
    logic        s;
    logic [4:0]  ea, eb;
    logic [3:0]  za, zb;
    logic [10:0] sa, sb;
    logic [21:0] p, pn;
    logic signed [7:0] e;
    logic [5:0]  sh;
    logic [43:0] ext;
    logic [10:0] q;
    logic        rbit, sticky;
    logic [15:0] r;
    s  = a[15] ^ b[15];
    ea = a[14:10];
    eb = b[14:10];
    za = lzc10(a[9:0]);
    zb = lzc10(b[9:0]);
    sa = (ea == 5'd0) ? ({1'b0, a[9:0]} << (za + 4'd1)) : {1'b1, a[9:0]};
    sb = (eb == 5'd0) ? ({1'b0, b[9:0]} << (zb + 4'd1)) : {1'b1, b[9:0]};
    p  = 22'(sa) * 22'(sb);
    e  = ((ea == 5'd0) ? (8'sd1 - 8'(za) - 8'sd1) : 8'(ea))
       + ((eb == 5'd0) ? (8'sd1 - 8'(zb) - 8'sd1) : 8'(eb));
    if (p[21]) begin
      pn = p;
      e  = e - 8'sd14;
    end else begin
      pn = p << 1;
      e  = e - 8'sd15;
    end
    r = 16'd0;
    if (ea == EXP_MAX || eb == EXP_MAX) begin
      r = INF_BITS;
    end else if (a[14:0] == 15'd0 || b[14:0] == 15'd0) begin
      r = 16'd0;
    end else if (e >= 8'sd31) begin
      r = INF_BITS;
    end else if (e >= 8'sd1) begin
      rbit   = pn[10];
      sticky = |pn[9:0];
      r = {1'b0, e[4:0], pn[20:11]};
      if (rbit && (sticky || r[0])) r = r + 16'd1;
    end else if (e < -8'sd10) begin
      r = 16'd0;
    end else begin
      sh     = 6'(8'sd12 - e);
      ext    = {pn, 22'd0} >> sh;
      q      = ext[32:22];
      rbit   = ext[21];
      sticky = |ext[20:0];
      if (rbit && (sticky || q[0])) q = q + 11'd1;
      r = {5'd0, q};
    end
    return r | (s ? SIGN_MASK : 16'd0);
  endfunction

endpackage

FILE: rtl/half_float_multiply_unit.sv
// ----------------------------------------------------------------------------
// half_float_multiply_unit
// Elementwise binary16 multiplier with round to nearest even.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries in_a_bits, in_b_bits, in_last_in.
//   Result channel out_valid/out_ready carries out_product_bits, out_last_out.
//   NaN or infinite operands give signed infinity; no NaN is produced.
// Path: an accepted input passes through the input register and then the
//   result register before out_valid rises.
// Throughput: one transaction per cycle unless stalled, set by the
//   single-pass product logic between the input and result registers.
// Reset: rst_n (synchronous, active low) empties both register stages.
// Stall: a stalled receiver holds the result register; the input stage
//   keeps moving while the result stage has room, so both stages fill
//   before in_ready drops.
module half_float_multiply_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] in_a_bits,
  input  logic [15:0] in_b_bits,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_product_bits,
  output logic        out_last_out
);
  import hfm_pkg::*;

  logic        s1_vld_r;
  logic [15:0] s1_a_r, s1_b_r;
  logic        s1_last_r;
  logic        s2_vld_r;
  logic [15:0] s2_prod_r;
  logic        s2_last_r;
  logic        s2_ready, s1_ready;

  // Stage enables
  assign s2_ready = !s2_vld_r || out_ready;
  assign s1_ready = !s1_vld_r || s2_ready;
  assign in_ready = s1_ready;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_ready) begin
      s1_vld_r <= in_valid;
    end
    if (s1_ready && in_valid) begin
      s1_a_r    <= in_a_bits;
      s1_b_r    <= in_b_bits;
      s1_last_r <= in_last_in;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_ready) begin
      s2_vld_r <= s1_vld_r;
    end
    if (s2_ready && s1_vld_r) begin
      s2_prod_r <= hmul(s1_a_r, s1_b_r);
      s2_last_r <= s1_last_r;
    end
  end

  assign out_valid        = s2_vld_r;
  assign out_product_bits = s2_prod_r;
  assign out_last_out     = s2_last_r;
endmodule

FILE: rtl/hfm_checker.sv
// ----------------------------------------------------------------------------
// hfm_checker
// Port-level checks for the half float multiplier.
// ----------------------------------------------------------------------------
`include "half_float_multiply_unit_assert.svh"
module hfm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_product_bits
);
  // Stalled result holds
  `HFM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_product_bits))
  // Input transaction taken with out_ready high is followed by out_valid
  `HFM_ASSERT_NEXT(a_in_flow, clk, rst_n, in_valid && in_ready && out_ready, ##1 out_valid)
  // Ready drops only when a result is stalled
  `HFM_ASSERT_IMPL(a_ready, clk, rst_n, !in_ready, out_valid && !out_ready)
endmodule

bind half_float_multiply_unit hfm_checker u_hfm_checker (.*);

FILE: tb/tb_half_float_multiply_unit.sv
// ----------------------------------------------------------------------------
// tb_half_float_multiply_unit
// Checks the binary16 multiplier against an independent RNE product model,
// with directed corner operands, random operands and random backpressure.
// ----------------------------------------------------------------------------
module tb_half_float_multiply_unit;

  typedef struct packed {
    logic [15:0] a;
    logic [15:0] b;
    logic        last;
  } operand_pair_t;

  typedef struct packed {
    logic [15:0] product;
    logic        last;
  } product_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [15:0] in_a_bits;
  logic [15:0] in_b_bits;
  logic        in_last_in;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_product_bits;
  logic        out_last_out;

  operand_pair_t pending_pairs[$];
  product_t      expected_products[$];
  int            error_count = 0;
  int            send_idle_pct;
  int            recv_stall_pct;
  bit            hold_sender;
  bit            stim_done;
  bit            in_taken;

  half_float_multiply_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a_bits(in_a_bits), .in_b_bits(in_b_bits), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_product_bits(out_product_bits), .out_last_out(out_last_out)
  );

  // Clock
  always #6 clk = ~clk;

  // Expected binary16 product, round to nearest even, NaN folded to infinity
  function automatic logic [15:0] rne_product(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] sgn;
    logic [10:0] ma, mb;
    int          xa, xb, ex, sh;
    logic [21:0] prod;
    logic [15:0] q;
    logic        rnd;
    logic        stk;
    sgn = (a ^ b) & hfm_pkg::SIGN_MASK;
    if (a[14:10] == hfm_pkg::EXP_MAX || b[14:10] == hfm_pkg::EXP_MAX)
      return sgn | hfm_pkg::INF_BITS;
    if (a[14:0] == 15'd0 || b[14:0] == 15'd0) return sgn;
    ma = {1'b0, a[9:0]};
    xa = 1;
    if (a[14:10] == 5'd0) begin
      while (!ma[10]) begin
        ma = ma << 1;
        xa--;
      end
    end else begin
      ma[10] = 1'b1;
      xa = a[14:10];
    end
    mb = {1'b0, b[9:0]};
    xb = 1;
    if (b[14:10] == 5'd0) begin
      while (!mb[10]) begin
        mb = mb << 1;
        xb--;
      end
    end else begin
      mb[10] = 1'b1;
      xb = b[14:10];
    end
    prod = 22'(ma) * 22'(mb);
    if (prod[21]) begin
      ex = xa + xb - 14;
    end else begin
      prod = prod << 1;
      ex = xa + xb - 15;
    end
    if (ex >= 31) return sgn | hfm_pkg::INF_BITS;
    if (ex >= 1) begin
      q = {1'b0, 5'(ex), prod[20:11]};
      rnd = prod[10];
      stk = |prod[9:0];
    end else if (ex < -10) begin
      return sgn;
    end else begin
      sh = 12 - ex;
      q = 16'(prod >> sh);
      rnd = prod[sh - 1];
      stk = (prod & ((22'd1 << (sh - 1)) - 22'd1)) != 22'd0;
    end
    // carry out of the fraction rolls into the exponent, up to infinity
    if (rnd && (stk || q[0])) q = q + 16'd1;
    return sgn | q;
  endfunction

  function automatic logic [15:0] pick_operand();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 9))
      0: v[14:10] = 5'd0;
      1: v[14:10] = hfm_pkg::EXP_MAX;
      2: v[14:10] = 5'($urandom_range(1, 6));
      3: v[14:10] = 5'($urandom_range(24, 30));
      4: v[14:0] = 15'd0;
      default: v[14:10] = 5'($urandom_range(8, 22));
    endcase
    return v;
  endfunction

  task automatic queue_pair(input logic [15:0] a, input logic [15:0] b, input logic last);
    pending_pairs.push_back('{a: a, b: b, last: last});
  endtask

  task automatic wait_drained();
    while (pending_pairs.size() != 0 || in_valid || expected_products.size() != 0)
      @(posedge clk);
  endtask

  // Input transaction seen at the last rising edge
  always @(posedge clk) begin
    in_taken <= in_valid && in_ready;
  end

  // Driver: present at falling edge, hold until accepted
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      in_a_bits  <= '0;
      in_b_bits  <= '0;
      in_last_in <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_pairs.size() != 0 && !hold_sender &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid   <= 1'b1;
        in_a_bits  <= pending_pairs[0].a;
        in_b_bits  <= pending_pairs[0].b;
        in_last_in <= pending_pairs[0].last;
        void'(pending_pairs.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall
  always @(negedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: predict on input transaction, check on result transaction
  always @(posedge clk) begin
    product_t got, want;
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_products.push_back('{product: rne_product(in_a_bits, in_b_bits),
                                      last: in_last_in});
      if (out_valid && out_ready) begin
        got = '{product: out_product_bits, last: out_last_out};
        if (expected_products.size() == 0) begin
          $error("unexpected result transaction product=%h", got.product);
          error_count++;
        end else begin
          want = expected_products.pop_front();
          if (got.product !== want.product) begin
            $error("product_bits expected %h actual %h", want.product, got.product);
            error_count++;
          end
          if (got.last !== want.last) begin
            $error("last_out expected %b actual %b", want.last, got.last);
            error_count++;
          end
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic [15:0] corners[12];
    corners = '{16'h0000, 16'h8000, 16'h0001, 16'h03ff, 16'h0400, 16'h3c00,
                16'hbc00, 16'h7bff, 16'h7c00, 16'hfc00, 16'h7e01, 16'h3555};
    stim_done = 1'b0;
    hold_sender = 1'b0;
    send_idle_pct = 7;
    recv_stall_pct = 52;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: inf*zero, NaN, overflow, underflow tie, subnormal rounding up
    queue_pair(16'h7c00, 16'h0000, 1'b0);
    queue_pair(16'h7e00, 16'h3c00, 1'b1);
    queue_pair(16'h7bff, 16'h7bff, 1'b0);
    queue_pair(16'h7bff, 16'h3c01, 1'b0);
    queue_pair(16'h0001, 16'h3800, 1'b0);
    queue_pair(16'h0001, 16'h3801, 1'b1);
    queue_pair(16'h0001, 16'h0001, 1'b0);
    queue_pair(16'h03ff, 16'h3c01, 1'b0);
    queue_pair(16'h8001, 16'h3e00, 1'b1);
    queue_pair(16'hffff, 16'hffff, 1'b1);
    for (int i = 0; i < 12; i++)
      queue_pair(corners[i], corners[(i * 5 + 3) % 12], 1'(i));

    // Random, three backpressure phases
    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < 380; i++)
        queue_pair(pick_operand(), pick_operand(), 1'($urandom_range(0, 1)));
      if (ph == 0) begin
        // pause sending until all results are back
        while (pending_pairs.size() > 150) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_products.size() != 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
      send_idle_pct  = (ph == 0) ? 52 : 0;
      recv_stall_pct = (ph == 0) ? 7 : 0;
    end
    repeat (10) @(posedge clk);
    stim_done = 1'b1;
  end

  // End of run
  initial begin
    wait (stim_done);
    if (error_count == 0)
      $display("tb_half_float_multiply_unit: clean");
    else
      $display("tb_half_float_multiply_unit: errors");
    $finish;
  end

  // Timeout
  initial begin
    #2000000;
    $display("tb_half_float_multiply_unit: errors");
    $finish;
  end

endmodule
